// File: sv/grmt_pkg.sv
// ----------------------------------------------------------------------------
// grmt_pkg
// Shared types and constants of the grid range maximum tree.
// ----------------------------------------------------------------------------
package grmt_pkg;
	localparam int GRID_SIZE  = 64;
	localparam int VALUE_BITS = 16;
	localparam int COORD_BITS = 6;
	localparam int SPAN       = 2 * GRID_SIZE;
	localparam int NODE_BITS  = $clog2(SPAN);
	localparam int ADDR_BITS  = 2 * NODE_BITS;
	localparam int DEPTH      = SPAN * SPAN;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	typedef logic [NODE_BITS-1:0]  node_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [VALUE_BITS-1:0] value_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LEAF_RD,
		ST_LEAF_WR,
		ST_PAIR_A,
		ST_PAIR_B,
		ST_PAIR_WR,
		ST_QX,
		ST_QY,
		ST_QRD,
		ST_QACC,
		ST_DONE
	} state_t;
endpackage

// File: sv/grid_range_max_tree_unit.sv
// ----------------------------------------------------------------------------
// grid_range_max_tree_unit
// Two-dimensional segment tree of maxima held in one synchronous memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The memory has
// one read and one write port, and the block makes at most one access per cycle.
// A clear sweeps all 16384 entries, one per cycle, and the block also runs that
// sweep after reset while busy stays high. An update reads the leaf and
// rewrites it with the larger of its old value and new_value, then reads both
// children of each tree node it recomputes and writes their maximum: six
// nodes on the leaf row and seven on each of the six rows above it. A query
// visits at most ten column nodes and at most ten row nodes under each, and
// an empty rectangle goes straight to done. The result of a query is on
// range_max while done is high for one cycle; the receiver cannot hold it
// off and must take it in that cycle.
module grid_range_max_tree_unit import grmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [5:0]  point_x,
	input  logic [5:0]  point_y,
	input  logic [15:0] new_value,
	input  logic [5:0]  x_low,
	input  logic [5:0]  x_high,
	input  logic [5:0]  y_low,
	input  logic [5:0]  y_high,
	output logic        done,
	output logic [15:0] range_max
);
	value_t mem [DEPTH];
	value_t rd_q;
	state_t state_q, state_d;

	addr_t  clr_q;
	node_t  x_q, y_q, y0_q;
	value_t val_q, a_q, best_q;
	logic [NODE_BITS:0] xl_q, xr_q, yl_q, yr_q, yl0_q, yr0_q;
	node_t  qx_q;
	logic   leaf_row_q;

	logic   we, re;
	addr_t  waddr, raddr;
	value_t wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	logic [NODE_BITS-1:0] xh_sat, yh_sat;
	always_comb begin
		xh_sat = (x_high >= COORD_BITS'(GRID_SIZE - 1)) ?
			NODE_BITS'(GRID_SIZE - 1) : NODE_BITS'(x_high);
		yh_sat = (y_high >= COORD_BITS'(GRID_SIZE - 1)) ?
			NODE_BITS'(GRID_SIZE - 1) : NODE_BITS'(y_high);
	end

	logic q_empty;
	assign q_empty = (NODE_BITS'(x_low) > xh_sat) || (NODE_BITS'(y_low) > yh_sat);

	value_t pair_max;
	assign pair_max = (a_q > rd_q) ? a_q : rd_q;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		re = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_CLEAR)
						state_d = ST_CLEAR;
					else if (command == CMD_UPDATE)
						state_d = ST_LEAF_RD;
					else if (command == CMD_QUERY)
						state_d = q_empty ? ST_DONE : ST_QX;
				end
			end
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				if (clr_q == addr_t'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_LEAF_RD: begin
				re = 1'b1;
				raddr = {x_q, y_q};
				state_d = ST_LEAF_WR;
			end
			ST_LEAF_WR: begin
				we = 1'b1;
				waddr = {x_q, y_q};
				wdata = (rd_q > val_q) ? rd_q : val_q;
				state_d = ST_PAIR_A;
			end
			ST_PAIR_A: begin
				re = 1'b1;
				raddr = leaf_row_q ? {x_q, y_q[NODE_BITS-2:0], 1'b0}
					: {x_q[NODE_BITS-2:0], 1'b0, y_q};
				state_d = ST_PAIR_B;
			end
			ST_PAIR_B: begin
				re = 1'b1;
				raddr = leaf_row_q ? {x_q, y_q[NODE_BITS-2:0], 1'b1}
					: {x_q[NODE_BITS-2:0], 1'b1, y_q};
				state_d = ST_PAIR_WR;
			end
			ST_PAIR_WR: begin
				we = 1'b1;
				waddr = {x_q, y_q};
				wdata = pair_max;
				if (y_q == node_t'(1) && x_q == node_t'(1))
					state_d = ST_IDLE;
				else
					state_d = ST_PAIR_A;
			end
			ST_QX: begin
				if (xl_q >= xr_q)
					state_d = ST_DONE;
				else if (xl_q[0] || xr_q[0])
					state_d = ST_QY;
			end
			ST_QY: begin
				if (yl_q >= yr_q)
					state_d = ST_QX;
				else if (yl_q[0] || yr_q[0])
					state_d = ST_QRD;
			end
			ST_QRD: begin
				re = 1'b1;
				raddr = {qx_q, y_q};
				state_d = ST_QACC;
			end
			ST_QACC: state_d = ST_QY;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			x_q <= '0;
			y_q <= '0;
			y0_q <= '0;
			val_q <= '0;
			a_q <= '0;
			best_q <= '0;
			xl_q <= '0;
			xr_q <= '0;
			yl_q <= '0;
			yr_q <= '0;
			yl0_q <= '0;
			yr0_q <= '0;
			qx_q <= '0;
			leaf_row_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (command == CMD_CLEAR) begin
							clr_q <= '0;
						end else if (command == CMD_UPDATE) begin
							x_q <= node_t'(GRID_SIZE) | node_t'(point_x);
							y_q <= node_t'(GRID_SIZE) | node_t'(point_y);
							y0_q <= node_t'(GRID_SIZE) | node_t'(point_y);
							val_q <= value_t'(new_value);
							leaf_row_q <= 1'b1;
						end else if (command == CMD_QUERY) begin
							best_q <= '0;
							xl_q <= (NODE_BITS+1)'(x_low) + (NODE_BITS+1)'(GRID_SIZE);
							xr_q <= (NODE_BITS+1)'(xh_sat) + (NODE_BITS+1)'(GRID_SIZE + 1);
							yl0_q <= (NODE_BITS+1)'(y_low) + (NODE_BITS+1)'(GRID_SIZE);
							yr0_q <= (NODE_BITS+1)'(yh_sat) + (NODE_BITS+1)'(GRID_SIZE + 1);
						end
					end
				end
				ST_CLEAR: clr_q <= clr_q + addr_t'(1);
				ST_LEAF_WR: y_q <= y_q >> 1;
				ST_PAIR_B: a_q <= rd_q;
				ST_PAIR_WR: begin
					if (y_q != node_t'(1)) begin
						y_q <= y_q >> 1;
					end else if (x_q != node_t'(1)) begin
						x_q <= x_q >> 1;
						y_q <= y0_q;
						leaf_row_q <= 1'b0;
					end
				end
				ST_QX: begin
					if (xl_q < xr_q) begin
						if (xl_q[0]) begin
							qx_q <= xl_q[NODE_BITS-1:0];
							xl_q <= xl_q + 1'b1;
							yl_q <= yl0_q;
							yr_q <= yr0_q;
						end else if (xr_q[0]) begin
							qx_q <= xr_q[NODE_BITS-1:0] - 1'b1;
							xr_q <= xr_q - 1'b1;
							yl_q <= yl0_q;
							yr_q <= yr0_q;
						end else begin
							xl_q <= xl_q >> 1;
							xr_q <= xr_q >> 1;
						end
					end
				end
				ST_QY: begin
					if (yl_q < yr_q) begin
						if (yl_q[0]) begin
							y_q <= yl_q[NODE_BITS-1:0];
							yl_q <= yl_q + 1'b1;
						end else if (yr_q[0]) begin
							y_q <= yr_q[NODE_BITS-1:0] - 1'b1;
							yr_q <= yr_q - 1'b1;
						end else begin
							yl_q <= yl_q >> 1;
							yr_q <= yr_q >> 1;
						end
					end
				end
				ST_QACC: if (rd_q > best_q) best_q <= rd_q;
				default: ;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign range_max = best_q;
endmodule

// File: sv/grmt_checker.sv
// ----------------------------------------------------------------------------
// grmt_checker
// Port-level checks of the grid range maximum tree.
// ----------------------------------------------------------------------------
module grmt_checker import grmt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [1:0] command
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside a transaction");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_upd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_UPDATE) |=> busy)
		else $error("update did not start");
	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_CLEAR) |=> busy && !done)
		else $error("clear did not start");
endmodule

bind grid_range_max_tree_unit grmt_checker u_grmt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .command(command)
);
